@@ design/trq_pkg.sv @@
// ----------------------------------------------------------------------------
// trq_pkg: shared types and constants of the topic ring queue
// queue geometry, field widths, operation and status codes, slot addressing
// ----------------------------------------------------------------------------
package trq_pkg;

    // queue geometry
    localparam int NUM_TOPICS  = 4;
    localparam int QUEUE_DEPTH = 8;
    localparam int SLOTS       = NUM_TOPICS * QUEUE_DEPTH;

    // derived widths
    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int QIDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int TIDX_W = (NUM_TOPICS > 1) ? $clog2(NUM_TOPICS) : 1;

    // field widths
    localparam int OP_W     = 2;
    localparam int TOPIC_W  = 2;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;

    // reset values
    localparam logic [DATA_W-1:0] EXPIRE_RESET   = 32'd3000;
    localparam logic [DATA_W-1:0] NEXT_SEQ_RESET = 32'd1;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ENQ    = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_DEQ    = 2'd2
    } t_op;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE    = 3'd0,
        STAT_FULL    = 3'd1,
        STAT_EMPTY   = 3'd2,
        STAT_NOMATCH = 3'd3,
        STAT_NOEXP   = 3'd4
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_AGE,
        ST_RESULT
    } t_state;

    // one stored entry
    typedef struct packed {
        logic [DATA_W-1:0] seq;
        logic [DATA_W-1:0] stamp;
        logic [DATA_W-1:0] publisher;
        logic [DATA_W-1:0] payload;
    } t_entry;

    // one request transaction
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [TOPIC_W-1:0] topic;
        logic [DATA_W-1:0]  now;
        logic [DATA_W-1:0]  last_seq;
        logic [DATA_W-1:0]  publisher;
        logic [DATA_W-1:0]  payload;
        logic               payload_present;
    } t_req;

    // one response transaction
    typedef struct packed {
        logic              ok;
        t_status           status;
        logic [DATA_W-1:0] entry_seq;
        logic [DATA_W-1:0] entry_stamp;
        logic [DATA_W-1:0] entry_publisher;
        logic [DATA_W-1:0] entry_payload;
    } t_result;

    // ring position head + offset, both below the depth
    function automatic logic [QIDX_W-1:0] ring_pos(logic [QIDX_W-1:0] head,
                                                   logic [QIDX_W-1:0] offset);
        logic [QIDX_W:0] pos;
        pos = {1'b0, head} + {1'b0, offset};
        if (pos >= (QIDX_W+1)'(QUEUE_DEPTH)) begin
            pos = pos - (QIDX_W+1)'(QUEUE_DEPTH);
        end
        return pos[QIDX_W-1:0];
    endfunction

    // memory address of a slot of one topic queue
    function automatic logic [ADDR_W-1:0] slot_addr(logic [TOPIC_W-1:0] topic,
                                                    logic [QIDX_W-1:0]  head,
                                                    logic [QIDX_W-1:0]  offset);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(topic) * ADDR_W'(QUEUE_DEPTH);
        return base + ADDR_W'(ring_pos(head, offset));
    endfunction

endpackage

@@ design/trq_if.sv @@
// ----------------------------------------------------------------------------
// trq_if: request and response channel interfaces
// valid/ready channels carrying one transaction per handshake
// ----------------------------------------------------------------------------

// request channel
interface trq_req_if;
    logic                         valid;
    logic                         ready;
    logic [trq_pkg::OP_W-1:0]     op;
    logic [trq_pkg::TOPIC_W-1:0]  topic;
    logic [trq_pkg::DATA_W-1:0]   now;
    logic [trq_pkg::DATA_W-1:0]   last_seq;
    logic [trq_pkg::DATA_W-1:0]   publisher;
    logic [trq_pkg::DATA_W-1:0]   payload;
    logic                         payload_present;

    modport source (
        output valid, op, topic, now, last_seq, publisher, payload, payload_present,
        input  ready
    );
    modport sink (
        input  valid, op, topic, now, last_seq, publisher, payload, payload_present,
        output ready
    );
endinterface

// response channel
interface trq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [trq_pkg::STATUS_W-1:0]  status;
    logic [trq_pkg::DATA_W-1:0]    entry_seq;
    logic [trq_pkg::DATA_W-1:0]    entry_stamp;
    logic [trq_pkg::DATA_W-1:0]    entry_publisher;
    logic [trq_pkg::DATA_W-1:0]    entry_payload;

    modport source (
        output valid, ok, status, entry_seq, entry_stamp, entry_publisher,
               entry_payload,
        input  ready
    );
    modport sink (
        input  valid, ok, status, entry_seq, entry_stamp, entry_publisher,
               entry_payload,
        output ready
    );
endinterface

@@ design/trq_store.sv @@
// ----------------------------------------------------------------------------
// trq_store: entry memory of all topic queues
// one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module trq_store (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [trq_pkg::ADDR_W-1:0]  i_wr_addr,
    input  trq_pkg::t_entry             i_wr_data,
    input  logic                        i_rd_en,
    input  logic [trq_pkg::ADDR_W-1:0]  i_rd_addr,
    output trq_pkg::t_entry             o_rd_data
);

    trq_pkg::t_entry r_mem [trq_pkg::SLOTS];
    trq_pkg::t_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/trq_ctrl.sv @@
// ----------------------------------------------------------------------------
// trq_ctrl: sequencer of the topic ring queue
// queue pointers, sequence counter, age register and one shared compare unit
// ----------------------------------------------------------------------------
module trq_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [trq_pkg::DATA_W-1:0]  i_cfg_wdata,
    input  logic                        i_req_valid,
    input  trq_pkg::t_req               i_req,
    output logic                        o_req_ready,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output trq_pkg::t_result            o_res
);

    localparam int QIDX_W = trq_pkg::QIDX_W;
    localparam int CNT_W  = trq_pkg::CNT_W;
    localparam int TIDX_W = trq_pkg::TIDX_W;
    localparam int ADDR_W = trq_pkg::ADDR_W;
    localparam int DATA_W = trq_pkg::DATA_W;

    trq_pkg::t_state   r_state, n_state;
    trq_pkg::t_req     r_req, n_req;
    trq_pkg::t_result  r_res, n_res;
    logic [QIDX_W-1:0] r_head [trq_pkg::NUM_TOPICS];
    logic [QIDX_W-1:0] n_head [trq_pkg::NUM_TOPICS];
    logic [CNT_W-1:0]  r_fill [trq_pkg::NUM_TOPICS];
    logic [CNT_W-1:0]  n_fill [trq_pkg::NUM_TOPICS];
    logic [DATA_W-1:0] r_next_seq, n_next_seq;
    logic [DATA_W-1:0] r_expire;
    logic [QIDX_W-1:0] r_k, n_k;

    logic               w_topic_ok;
    logic [TIDX_W-1:0]  w_tix;
    logic [QIDX_W-1:0]  w_head;
    logic [CNT_W-1:0]   w_fill;
    logic [CNT_W-1:0]   w_k_next;
    logic [DATA_W-1:0]  w_cmp_a, w_cmp_b;
    logic               w_gt;
    logic               w_wr_en, w_rd_en;
    logic [ADDR_W-1:0]  w_wr_addr, w_rd_addr;
    trq_pkg::t_entry    w_wr_data, w_rd_data;

    // entry memory
    trq_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // addressed queue
    assign w_topic_ok = int'(r_req.topic) < trq_pkg::NUM_TOPICS;
    assign w_tix      = TIDX_W'(r_req.topic);
    assign w_head     = r_head[w_tix];
    assign w_fill     = r_fill[w_tix];
    assign w_k_next   = CNT_W'(r_k) + CNT_W'(1);

    // shared compare unit: sequence against last seen, or age against limit
    always_comb begin
        if (r_state == trq_pkg::ST_AGE) begin
            w_cmp_a = r_req.now - w_rd_data.stamp;
            w_cmp_b = r_expire;
        end else begin
            w_cmp_a = w_rd_data.seq;
            w_cmp_b = r_req.last_seq;
        end
        w_gt = w_cmp_a > w_cmp_b;
    end

    // next state and datapath control
    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_res      = r_res;
        n_head     = r_head;
        n_fill     = r_fill;
        n_next_seq = r_next_seq;
        n_k        = r_k;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        w_wr_en    = 1'b0;
        w_rd_en    = 1'b0;
        w_rd_addr  = trq_pkg::slot_addr(r_req.topic, w_head, '0);
        w_wr_addr  = trq_pkg::slot_addr(r_req.topic, w_head, QIDX_W'(w_fill));
        w_wr_data  = '{seq: r_next_seq, stamp: r_req.now,
                       publisher: r_req.publisher, payload: r_req.payload};

        unique case (r_state)
            trq_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_req   = i_req;
                    n_state = trq_pkg::ST_DECODE;
                end
            end

            trq_pkg::ST_DECODE: begin
                n_res   = '0;
                n_state = trq_pkg::ST_RESULT;
                unique case (trq_pkg::t_op'(r_req.op))
                    trq_pkg::OP_ENQ: begin
                        if (!w_topic_ok || w_fill >= CNT_W'(trq_pkg::QUEUE_DEPTH)) begin
                            n_res.status = trq_pkg::STAT_FULL;
                        end else if (!r_req.payload_present) begin
                            n_res.status = trq_pkg::STAT_DONE;
                        end else begin
                            w_wr_en         = 1'b1;
                            n_res.ok        = 1'b1;
                            n_res.status    = trq_pkg::STAT_DONE;
                            n_res.entry_seq = r_next_seq;
                            n_next_seq      = r_next_seq + DATA_W'(1);
                            n_fill[w_tix]   = w_fill + CNT_W'(1);
                        end
                    end
                    trq_pkg::OP_LOOKUP: begin
                        if (!w_topic_ok || w_fill == '0) begin
                            n_res.status = trq_pkg::STAT_EMPTY;
                        end else begin
                            w_rd_en = 1'b1;
                            n_k     = '0;
                            n_state = trq_pkg::ST_SCAN;
                        end
                    end
                    trq_pkg::OP_DEQ: begin
                        if (!w_topic_ok || w_fill == '0) begin
                            n_res.status = trq_pkg::STAT_EMPTY;
                        end else begin
                            w_rd_en = 1'b1;
                            n_state = trq_pkg::ST_AGE;
                        end
                    end
                    default: begin
                        n_res.status = trq_pkg::STAT_NOMATCH;
                    end
                endcase
            end

            // one entry compared per cycle, next read issued alongside
            trq_pkg::ST_SCAN: begin
                if (w_gt) begin
                    n_res                 = '0;
                    n_res.ok              = 1'b1;
                    n_res.status          = trq_pkg::STAT_DONE;
                    n_res.entry_seq       = w_rd_data.seq;
                    n_res.entry_stamp     = w_rd_data.stamp;
                    n_res.entry_publisher = w_rd_data.publisher;
                    n_res.entry_payload   = w_rd_data.payload;
                    n_state               = trq_pkg::ST_RESULT;
                end else if (w_k_next == w_fill) begin
                    n_res        = '0;
                    n_res.status = trq_pkg::STAT_NOMATCH;
                    n_state      = trq_pkg::ST_RESULT;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = trq_pkg::slot_addr(r_req.topic, w_head, QIDX_W'(w_k_next));
                    n_k       = QIDX_W'(w_k_next);
                end
            end

            // oldest entry aged out or not
            trq_pkg::ST_AGE: begin
                n_res   = '0;
                n_state = trq_pkg::ST_RESULT;
                if (w_gt) begin
                    n_res.ok        = 1'b1;
                    n_res.status    = trq_pkg::STAT_DONE;
                    n_res.entry_seq = w_rd_data.seq;
                    n_head[w_tix]   = trq_pkg::ring_pos(w_head, QIDX_W'(1));
                    n_fill[w_tix]   = w_fill - CNT_W'(1);
                end else begin
                    n_res.status = trq_pkg::STAT_NOEXP;
                end
            end

            trq_pkg::ST_RESULT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = trq_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = trq_pkg::ST_IDLE;
            end
        endcase
    end

    // state register and queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= trq_pkg::ST_IDLE;
            r_head     <= '{default: '0};
            r_fill     <= '{default: '0};
            r_next_seq <= trq_pkg::NEXT_SEQ_RESET;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_fill     <= n_fill;
            r_next_seq <= n_next_seq;
        end
    end

    // age limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expire <= trq_pkg::EXPIRE_RESET;
        end else if (i_cfg_we) begin
            r_expire <= i_cfg_wdata;
        end
    end

    // request, result and scan index
    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_res <= n_res;
        r_k   <= n_k;
    end

    assign o_res = r_res;

endmodule

@@ design/topic_ring_queue_seq_lookup.sv @@
// ----------------------------------------------------------------------------
// topic_ring_queue_seq_lookup: per-topic ring queues with sequence lookup
// enqueue and refused operations go from decode to result, dequeue adds an age check,
// lookup scans k entries, at most 8, before the result; responses pass an output register
// throughput: one transaction at a time; the lookup scan compares one entry per cycle
// synchronous active-low reset clears pointers and counts, presets sequence and age limit
// ----------------------------------------------------------------------------
module topic_ring_queue_seq_lookup (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [trq_pkg::DATA_W-1:0]  i_cfg_wdata,
    trq_req_if.sink                     i_req,
    trq_rsp_if.source                   o_rsp
);

    trq_pkg::t_req    w_req;
    trq_pkg::t_result w_res;
    trq_pkg::t_result r_out;
    logic             r_out_valid;
    logic             w_res_valid;
    logic             w_res_ready;
    logic             w_req_ready;

    // request transaction into one struct
    assign w_req = '{op: i_req.op, topic: i_req.topic, now: i_req.now,
                     last_seq: i_req.last_seq, publisher: i_req.publisher,
                     payload: i_req.payload, payload_present: i_req.payload_present};

    trq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (i_req.valid),
        .i_req       (w_req),
        .o_req_ready (w_req_ready),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    assign i_req.ready = w_req_ready;

    // output register
    assign w_res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    // response transaction
    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.ok              = r_out.ok;
    assign o_rsp.status          = r_out.status;
    assign o_rsp.entry_seq       = r_out.entry_seq;
    assign o_rsp.entry_stamp     = r_out.entry_stamp;
    assign o_rsp.entry_publisher = r_out.entry_publisher;
    assign o_rsp.entry_payload   = r_out.entry_payload;

`ifndef SYNTHESIS
    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request accepted while another is in flight");

    // success always reports done
    a_ok_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.ok |-> o_rsp.status == trq_pkg::STAT_DONE)
        else $error("successful response with failure status");

    // failed responses carry no entry
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ok |-> o_rsp.entry_seq == '0 && o_rsp.entry_payload == '0)
        else $error("failed response carries entry data");
`endif

endmodule
